FILE: hdl/itra_pkg.sv
// Shared constants, types and the digit glyph table for the integer to text converter.
package itra_pkg;

  localparam int VALUE_W       = 32;
  localparam int MAX_DIGITS    = 30;
  localparam int DIGIT_W       = 4;
  localparam int RADIX_W       = 8;
  localparam int DIVISOR_W     = 5;
  localparam int CHAR_W        = 7;
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = (VALUE_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int WORK_W        = DIV_STEPS * BITS_PER_STEP;
  localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W         = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int MAX_RADIX     = 16;
  localparam int RADIX_RESET   = 10;
  localparam int PDATA_W       = 32;
  localparam int PADDR_W       = 3;

  // register index, taken from paddr[2]
  localparam logic REG_RADIX = 1'b0;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    unique case (d)
      4'h0: c = 7'h30;
      4'h1: c = 7'h31;
      4'h2: c = 7'h32;
      4'h3: c = 7'h33;
      4'h4: c = 7'h34;
      4'h5: c = 7'h35;
      4'h6: c = 7'h36;
      4'h7: c = 7'h37;
      4'h8: c = 7'h38;
      4'h9: c = 7'h39;
      4'ha: c = 7'h61;
      4'hb: c = 7'h62;
      4'hc: c = 7'h63;
      4'hd: c = 7'h64;
      4'he: c = 7'h65;
      4'hf: c = 7'h66;
      default: c = 7'h30;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/itra_if.sv
// Valid/ready channel interfaces for the input word and the character word.
interface itra_in_if import itra_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itra_out_if import itra_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic              bad_base;

  modport source (output valid, output character, output last, output bad_base, input ready);
  modport sink   (input valid, input character, input last, input bad_base, output ready);
endinterface

FILE: hdl/itra_div.sv
// Iterative divider by a small radix: eight quotient bits per cycle, restoring.
module itra_div import itra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [DIVISOR_W-1:0] divisor,
  input  div_req_t             req,
  output div_rsp_t             rsp
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [WORK_W-1:0]  work_r, work_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [WORK_W-1:0]  work_step;
  logic [DIGIT_W-1:0] rem_step;
  logic               last_step;

  // one chunk of long division; remainder always stays below the divisor
  always_comb begin
    logic [DIVISOR_W-1:0] r;
    logic [WORK_W-1:0]    w;
    r = {1'b0, rem_r};
    w = work_r;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      r = {r[DIGIT_W-1:0], w[WORK_W-1]};
      w = {w[WORK_W-2:0], 1'b0};
      if (r >= divisor) begin
        r    = r - divisor;
        w[0] = 1'b1;
      end
    end
    work_step = w;
    rem_step  = r[DIGIT_W-1:0];
  end

  assign last_step = (step_r == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      work_nxt = WORK_W'(req.dividend);
      rem_nxt  = '0;
    end else if (busy_r) begin
      work_nxt = work_step;
      rem_nxt  = rem_step;
      step_nxt = step_r + STEP_W'(1);
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = work_r[VALUE_W-1:0];
  assign rsp.remainder = rem_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= STEP_W'(DIV_STEPS - 1)))
    else $error("divider step count out of range");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && last_step && !req.start) |=> done_r)
    else $error("divider did not finish after its last step");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider reports done while still busy");

endmodule

FILE: hdl/integer_to_radix_ascii.sv
// A bad radix or zero gives one character: the taken word goes to the emit state, then to the output register.
// Otherwise each digit takes four divider steps (DIV_STEPS), then is stored as the divider restarts.
// At most 30 digits; then one character per cycle leaves the output register while the sink is ready, sign first.
// A new word is taken once the last character sits in the output register.
// Synchronous active-low reset: radix returns to 10, control clears; digit store unreset.
module integer_to_radix_ascii import itra_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  itra_in_if.sink            in_ch,
  itra_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  state_t             state_r, state_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic               bad_r, bad_nxt;
  logic               sign_r, sign_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIGIT_W-1:0] stack_r [MAX_DIGITS];
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_bad_r, out_bad_nxt;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               in_fire;
  logic               slot_free;
  logic               radix_ok;
  logic               neg;
  logic [VALUE_W-1:0] value_u;
  logic [VALUE_W-1:0] mag;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   cnt_dec;
  logic               div_stop;
  logic               stack_we;
  logic [IDX_W-1:0]   stack_wr_idx;
  logic [DIGIT_W-1:0] stack_wr_data;
  logic               cfg_wr;

  itra_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .divisor (radix_r[DIVISOR_W-1:0]),
    .req     (div_req),
    .rsp     (div_rsp)
  );

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIX);
  assign prdata = (paddr[2] == REG_RADIX) ? PDATA_W'(radix_r) : '0;
  assign radix_nxt = cfg_wr ? pwdata[RADIX_W-1:0] : radix_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign radix_ok    = (radix_r != '0) && (radix_r <= RADIX_W'(MAX_RADIX));

  assign value_u = in_ch.value;
  assign neg     = value_u[VALUE_W-1];
  // most negative value wraps to 2^(n-1), read as unsigned
  assign mag     = neg ? (~value_u + VALUE_W'(1)) : value_u;

  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign div_stop = (div_rsp.quotient == '0) || (cnt_inc == CNT_W'(MAX_DIGITS));

  assign div_req.start    = (in_fire && radix_ok && (mag != '0)) ||
                            ((state_r == ST_DIV) && div_rsp.done && !div_stop);
  assign div_req.dividend = (state_r == ST_IDLE) ? mag : div_rsp.quotient;

  always_comb begin
    state_nxt     = state_r;
    bad_nxt       = bad_r;
    sign_nxt      = sign_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    stack_we      = 1'b0;
    stack_wr_idx  = cnt_r[IDX_W-1:0];
    stack_wr_data = div_rsp.remainder;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!radix_ok) begin
            bad_nxt   = 1'b1;
            state_nxt = ST_EMIT;
          end else if (mag == '0) begin
            // zero: a single '0' digit
            stack_we      = 1'b1;
            stack_wr_idx  = '0;
            stack_wr_data = '0;
            cnt_nxt       = CNT_W'(1);
            sign_nxt      = 1'b0;
            bad_nxt       = 1'b0;
            state_nxt     = ST_EMIT;
          end else begin
            cnt_nxt   = '0;
            sign_nxt  = neg;
            bad_nxt   = 1'b0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          stack_we = 1'b1;
          cnt_nxt  = cnt_inc;
          if (div_stop) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (bad_r) begin
            out_char_nxt = CHAR_NONE;
            out_last_nxt = 1'b1;
            out_bad_nxt  = 1'b1;
            bad_nxt      = 1'b0;
            state_nxt    = ST_IDLE;
          end else if (sign_r) begin
            out_char_nxt = CHAR_MINUS;
            out_last_nxt = 1'b0;
            out_bad_nxt  = 1'b0;
            sign_nxt     = 1'b0;
          end else begin
            out_char_nxt = glyph(stack_r[cnt_dec[IDX_W-1:0]]);
            out_last_nxt = (cnt_r == CNT_W'(1));
            out_bad_nxt  = 1'b0;
            cnt_nxt      = cnt_dec;
            if (cnt_r == CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RADIX_W'(RADIX_RESET);
      bad_r       <= 1'b0;
      sign_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      bad_r       <= bad_nxt;
      sign_r      <= sign_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // digit store, LS digit at index 0
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
    if (stack_we) begin
      stack_r[stack_wr_idx] <= stack_wr_data;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.bad_base  = out_bad_r;

  a_div_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < CNT_W'(MAX_DIGITS)))
    else $error("digit store overrun during division");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && div_rsp.done) |=> (cnt_r == $past(cnt_inc)))
    else $error("digit count did not advance on a divider result");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && !bad_r && !sign_r) |-> (cnt_r != '0))
    else $error("emitting with no digits left");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && slot_free && (bad_r || (!sign_r && (cnt_r == CNT_W'(1)))))
    |=> ((state_r == ST_IDLE) && out_ch.valid && out_ch.last))
    else $error("final character did not close the word");

endmodule
